// ----- sv/flash_wear_leveling_word_store_core_assert.svh -----
// Assertion macros for the wear-leveling word store.
// Used by the core top level; expects clk and rst in scope.
`ifndef FLASH_WEAR_LEVELING_WORD_STORE_CORE_ASSERT_SVH
`define FLASH_WEAR_LEVELING_WORD_STORE_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define FWL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fwl_pkg.sv -----
// Shared types and constants for the wear-leveling word store.
// No dependencies.
package fwl_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 8;

  localparam logic [DATA_W-1:0] FLAG_ENABLED  = 32'hEEEE_EEEE;
  localparam logic [DATA_W-1:0] FLAG_DISABLED = 32'h8888_8888;
  localparam logic [DATA_W-1:0] FLAG_ERASED   = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] FRESH_VALUE   = 32'h0000_00FF;

  localparam logic [0:0] CMD_READ  = 1'b0;
  localparam logic [0:0] CMD_WRITE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_INIT0,
    S_ACCESS,
    S_RD_WAIT,
    S_COPY_RD,
    S_COPY_WR,
    S_DISABLE,
    S_BUF_RD,
    S_BUF_WR,
    S_DONE
  } fwl_state_t;

endpackage

// ----- sv/fwl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fwl_agu.sv -----
// Shared address adder: flash word address = block base + word offset.
// Depends on nothing; sized by the top level.
module fwl_agu #(
  parameter int AW = 10,
  parameter int OW = 5
) (
  input  logic [AW-1:0] base,
  input  logic [OW-1:0] offset,
  output logic [AW-1:0] addr
);

  localparam int SW = ((AW > OW) ? AW : OW) + 1;

  logic [SW-1:0] sum;

  assign sum  = SW'(base) + SW'(offset);
  assign addr = sum[AW-1:0];

endmodule

// ----- sv/flash_wear_leveling_word_store_core.sv -----
// Top level of the wear-leveling word store: sequencer, datapath, flash and buffer RAMs.
// Depends on fwl_pkg, fwl_ram, fwl_agu and the assertion macro header.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready, command, word_index,  | one access item
//          | write_value                               |
//  out     | out_valid, out_ready, read_data,          | one result item per item
//          | index_out_of_range, store_fresh           |
//
// Per item: S_SCAN_RD and S_SCAN_CHK per block flag scanned, then S_ACCESS and S_DONE;
// the next item is taken once back in S_IDLE. An in-range read of a written store
// adds S_RD_WAIT; an in-range write to a non-fresh store copies the block through
// the wrap buffer: S_COPY_RD/S_COPY_WR per word, S_DISABLE, then S_BUF_RD/S_BUF_WR
// per word. After reset the flash is swept to erased, one word a cycle, before the
// first item is taken; a scan that finds no enabled or erased block repeats it.
// A result waiting on out_ready holds its register; the next item may still enter.
`include "flash_wear_leveling_word_store_core_assert.svh"

module flash_wear_leveling_word_store_core #(
  parameter int STORE_WORDS = 1024,
  parameter int BLOCK_WORDS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [fwl_pkg::IDX_W-1:0]   word_index,
  input  logic [fwl_pkg::DATA_W-1:0]  write_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fwl_pkg::DATA_W-1:0]  read_data,
  output logic                        index_out_of_range,
  output logic                        store_fresh
);

  import fwl_pkg::*;

  localparam int BLK_COUNT = ((STORE_WORDS / BLOCK_WORDS) > 0) ?
                             (STORE_WORDS / BLOCK_WORDS) : 1;
  localparam int FLASH_LEN = BLK_COUNT * BLOCK_WORDS;
  localparam int AW  = $clog2(FLASH_LEN);
  localparam int OW  = $clog2(BLOCK_WORDS) + 1;
  localparam int BJW = $clog2(BLOCK_WORDS);
  localparam int BKW = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(BLOCK_WORDS - 1);
  localparam logic [OW-1:0]  BLK_STEP  = OW'(BLOCK_WORDS);

  fwl_state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic              erase_pend;
  logic              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] val_r;
  logic              oor_r;
  logic [AW-1:0]     base;
  logic [AW-1:0]     nbase;
  logic [BKW-1:0]    blk;
  logic [BJW-1:0]    j;
  logic              fresh;
  logic [DATA_W-1:0] rd_reg;

  logic              fl_we;
  logic [AW-1:0]     fl_waddr;
  logic [DATA_W-1:0] fl_wdata;
  logic [AW-1:0]     fl_raddr;
  logic [DATA_W-1:0] fl_rdata;
  logic              buf_we;
  logic [DATA_W-1:0] buf_wdata;
  logic [DATA_W-1:0] buf_rdata;
  logic [AW-1:0]     agu_a;
  logic [OW-1:0]     agu_b;
  logic [AW-1:0]     agu_addr;

  logic              clr_last, blk_last, j_last, out_free, copy_write;
  logic [IDX_W:0]    idx_p1;
  logic [OW-1:0]     idx_off;

  assign clr_last   = (clr_addr == AW'(FLASH_LEN - 1));
  assign blk_last   = (blk == BKW'(BLK_COUNT - 1));
  assign j_last     = (j == BJW'(BLOCK_WORDS - 1));
  assign out_free   = !out_valid || out_ready;
  assign idx_p1     = {1'b0, idx_r} + (IDX_W+1)'(1);
  assign idx_off    = OW'(idx_p1);
  assign copy_write = (cmd_r == CMD_WRITE) && !fresh;
  assign in_ready   = (state == S_IDLE);

  fwl_ram #(.WIDTH(DATA_W), .DEPTH(FLASH_LEN)) u_flash (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  fwl_ram #(.WIDTH(DATA_W), .DEPTH(BLOCK_WORDS)) u_wrap_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (j),
    .wdata (buf_wdata),
    .raddr (j),
    .rdata (buf_rdata)
  );

  fwl_agu #(.AW(AW), .OW(OW)) u_agu (
    .base   (agu_a),
    .offset (agu_b),
    .addr   (agu_addr)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = erase_pend ? S_INIT0 : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN_RD;
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        priority if (fl_rdata == FLAG_ENABLED || fl_rdata == FLAG_ERASED)
          state_next = S_ACCESS;
        else if (blk_last)
          state_next = S_CLEAR;
        else
          state_next = S_SCAN_RD;
      end
      S_INIT0: state_next = S_ACCESS;
      S_ACCESS: begin
        priority if (oor_r || fresh) state_next = S_DONE;
        else if (cmd_r == CMD_READ)  state_next = S_RD_WAIT;
        else                         state_next = S_COPY_RD;
      end
      S_RD_WAIT: state_next = S_DONE;
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: state_next = j_last ? S_DISABLE : S_COPY_RD;
      S_DISABLE: state_next = S_BUF_RD;
      S_BUF_RD:  state_next = S_BUF_WR;
      S_BUF_WR:  state_next = j_last ? S_DONE : S_BUF_RD;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory and adder controls
  always_comb begin
    fl_we     = 1'b0;
    fl_waddr  = agu_addr;
    fl_wdata  = FLAG_ERASED;
    fl_raddr  = agu_addr;
    buf_we    = 1'b0;
    buf_wdata = fl_rdata;
    agu_a     = base;
    agu_b     = '0;
    unique case (state)
      S_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_addr;
        fl_wdata = FLAG_ERASED;
      end
      S_SCAN_CHK: begin
        agu_b = BLK_STEP;
        if (fl_rdata == FLAG_ERASED) begin
          fl_we    = 1'b1;
          fl_waddr = '0;
          fl_wdata = FLAG_ENABLED;
        end
      end
      S_INIT0: begin
        fl_we    = 1'b1;
        fl_waddr = '0;
        fl_wdata = FLAG_ENABLED;
      end
      S_ACCESS: begin
        agu_b = copy_write ? BLK_STEP : idx_off;
        if (!oor_r && cmd_r == CMD_WRITE && fresh) begin
          fl_we    = 1'b1;
          fl_wdata = val_r;
        end
      end
      S_COPY_RD: agu_b = OW'(j);
      S_COPY_WR: begin
        buf_we = 1'b1;
        priority if (j == '0)            buf_wdata = FLAG_ENABLED;
        else if (OW'(j) == idx_off)      buf_wdata = val_r;
        else                             buf_wdata = fl_rdata;
      end
      S_DISABLE: begin
        fl_we    = 1'b1;
        fl_wdata = FLAG_DISABLED;
      end
      S_BUF_WR: begin
        agu_a    = nbase;
        agu_b    = OW'(j);
        fl_we    = 1'b1;
        fl_wdata = buf_rdata;
      end
      S_IDLE, S_SCAN_RD, S_RD_WAIT, S_BUF_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      erase_pend <= 1'b0;
      fresh      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (clr_last) begin
            clr_addr <= '0;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_SCAN_CHK: begin
          priority if (fl_rdata == FLAG_ENABLED) begin
          end else if (fl_rdata == FLAG_ERASED) begin
            fresh <= 1'b1;
          end else if (blk_last) begin
            erase_pend <= 1'b1;
          end
        end
        S_INIT0: begin
          fresh      <= 1'b1;
          erase_pend <= 1'b0;
        end
        S_ACCESS: begin
          if (!oor_r && cmd_r == CMD_WRITE && fresh) fresh <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r <= command;
          idx_r <= word_index;
          val_r <= write_value;
          oor_r <= ({1'b0, word_index} >= IDX_LIMIT);
          base  <= '0;
          blk   <= '0;
        end
      end
      S_SCAN_CHK: begin
        priority if (fl_rdata == FLAG_ENABLED) begin
        end else if (fl_rdata == FLAG_ERASED) begin
          base <= '0;
          blk  <= '0;
        end else if (!blk_last) begin
          base <= agu_addr;
          blk  <= blk + BKW'(1);
        end
      end
      S_INIT0: begin
        base <= '0;
        blk  <= '0;
      end
      S_ACCESS: begin
        rd_reg <= (!oor_r && cmd_r == CMD_READ && fresh) ? FRESH_VALUE : '0;
        j      <= '0;
        nbase  <= blk_last ? '0 : agu_addr;
      end
      S_RD_WAIT: rd_reg <= fl_rdata;
      S_COPY_WR, S_BUF_WR: j <= j_last ? '0 : j + BJW'(1);
      S_DONE: begin
        if (out_free) begin
          read_data          <= rd_reg;
          index_out_of_range <= oor_r;
          store_fresh        <= fresh;
        end
      end
      default: begin
      end
    endcase
  end

  `FWL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `FWL_ASSERT_NOW(a_flash_addr_range, fl_we, fl_waddr <= AW'(FLASH_LEN - 1), "write past array")
  `FWL_ASSERT_NOW(a_copy_flag_enabled, state == S_BUF_WR && j == '0, fl_wdata == FLAG_ENABLED, "copy flag")
  `FWL_ASSERT_NOW(a_oor_reads_zero, state == S_DONE && oor_r, rd_reg == '0, "oor data nonzero")

endmodule
